### rtl/seconds_to_date_time_top_macros.svh
// Assertion macros for the seconds to date/time converter checker.
`ifndef SECONDS_TO_DATE_TIME_TOP_MACROS_SVH
`define SECONDS_TO_DATE_TIME_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define S2DT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Invariant checked on every clock edge outside reset.
`define S2DT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

### rtl/s2dt_pkg.sv
// Types and constants shared by the seconds to date/time converter.
package s2dt_pkg;

  // time of day plus whole days, handed from the front to the back
  typedef struct packed {
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } s2dt_tod_t;

  // floor(x / 15) == (x * M) >> S, exact for x of the given width
  localparam logic [30:0] DIV15_M30 = 31'd1145324613;  // x < 2^30, shift 34
  localparam logic [25:0] DIV15_M25 = 26'd35791395;    // x < 2^25, shift 29
  // floor(x / 3), x < 2^18, shift 20
  localparam logic [18:0] DIV3_M18  = 19'd349526;
  // floor(x / 1461), x < 2^16, shift 27
  localparam logic [16:0] DIV1461_M16 = 17'd91868;

  localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
  localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;

  localparam int QUEUE_DEPTH = 2;

  // first day of each month within the four-year cycle, leap year first
  localparam logic [10:0] CYCLE_MONTH_START [0:47] = '{
    11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
    11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335,
    11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
    11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700,
    11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
    11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065,
    11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
    11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430
  };

endpackage

### rtl/seconds_to_date_time_top.sv
// Path: an accepted request is registered through front stages a to d, the queue and
// back stages s1 to s4 and the output registers; out_valid rises with the result.
// Throughput: one request per cycle; the front divider pipe and the back calendar
// pipe each take one item a cycle, and busy rises only when the two-entry queue
// between them is full, which an unstalled back end never lets happen.
// Reset: synchronous active-low rst_n clears all valid bits and queue pointers.
module seconds_to_date_time_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month,
  output logic [7:0]  out_year_offset
);

  logic                q_full;
  logic                push;
  logic                q_vld;
  s2dt_pkg::s2dt_tod_t front_tod;
  s2dt_pkg::s2dt_tod_t q_tod;

  assign busy = q_full;

  s2dt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (!q_full),
    .in_vld  (start && !busy),
    .in_secs (in_epoch_seconds),
    .push    (push),
    .tod     (front_tod)
  );

  s2dt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_tod),
    .pop     (1'b1),
    .rd_vld  (q_vld),
    .rd_data (q_tod),
    .full    (q_full)
  );

  s2dt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (q_vld),
    .in_tod           (q_tod),
    .out_valid        (out_valid),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year_offset  (out_year_offset)
  );

endmodule

### rtl/s2dt_front.sv
// Front end: splits seconds into second, minute, hour and whole days.
module s2dt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [31:0]           in_secs,
  output logic                  push,
  output s2dt_pkg::s2dt_tod_t   tod
);

  logic        a_v_r, b_v_r, c_v_r, d_v_r;
  logic [31:0] a_t_r;
  logic [5:0]  b_t_r;
  logic [26:0] b_q1_r;
  logic [5:0]  c_q1_r;
  logic [20:0] c_q2_r;
  logic [5:0]  c_sec_r;
  logic [4:0]  d_q2_r;
  logic [15:0] d_q3_r;
  logic [5:0]  d_min_r;
  logic [5:0]  d_sec_r;

  logic [60:0] prod1;
  logic [50:0] prod2;
  logic [36:0] prod3;
  logic [5:0]  sec_nxt;
  logic [5:0]  min_nxt;

  // t/60 = (t>>2)/15, q1/60 = (q1>>2)/15, q2/24 = (q2>>3)/3
  assign prod1 = 61'(a_t_r[31:2]) * 61'(s2dt_pkg::DIV15_M30);
  assign prod2 = 51'(b_q1_r[26:2]) * 51'(s2dt_pkg::DIV15_M25);
  assign prod3 = 37'(c_q2_r[20:3]) * 37'(s2dt_pkg::DIV3_M18);

  // remainders are below 64, so only the low bits matter
  assign sec_nxt = b_t_r - (b_q1_r[5:0] * s2dt_pkg::SECS_PER_MIN);
  assign min_nxt = c_q1_r - (c_q2_r[5:0] * s2dt_pkg::SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_vld;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_t_r   <= in_secs;
      b_t_r   <= a_t_r[5:0];
      b_q1_r  <= prod1[60:34];
      c_q1_r  <= b_q1_r[5:0];
      c_q2_r  <= prod2[49:29];
      c_sec_r <= sec_nxt;
      d_q2_r  <= c_q2_r[4:0];
      d_q3_r  <= prod3[35:20];
      d_min_r <= min_nxt;
      d_sec_r <= c_sec_r;
    end
  end

  assign push       = d_v_r && adv;
  assign tod.days   = d_q3_r;
  assign tod.hour   = d_q2_r - (d_q3_r[4:0] * s2dt_pkg::HOURS_PER_DAY);
  assign tod.minute = d_min_r;
  assign tod.second = d_sec_r;

endmodule

### rtl/s2dt_queue.sv
// Small queue between the front end and the calendar back end.
module s2dt_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  s2dt_pkg::s2dt_tod_t   wr_data,
  input  logic                  pop,
  output logic                  rd_vld,
  output s2dt_pkg::s2dt_tod_t   rd_data,
  output logic                  full
);

  localparam int PW = $clog2(s2dt_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(s2dt_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(s2dt_pkg::QUEUE_DEPTH - 1);

  s2dt_pkg::s2dt_tod_t mem_r [s2dt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && rd_vld;
  assign rd_vld  = (cnt_r != '0);
  assign full    = (cnt_r == CW'(s2dt_pkg::QUEUE_DEPTH));
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

### rtl/s2dt_back.sv
// Back end: four-year cycles, year within cycle, month and day lookup.
module s2dt_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  s2dt_pkg::s2dt_tod_t   in_tod,
  output logic                  out_valid,
  output logic [5:0]            out_second,
  output logic [5:0]            out_minute,
  output logic [4:0]            out_hour,
  output logic [4:0]            out_day_of_month,
  output logic [3:0]            out_month,
  output logic [7:0]            out_year_offset
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  s2dt_pkg::s2dt_tod_t s1_tod_r, s2_tod_r, s3_tod_r, s4_tod_r;
  logic [5:0]  s1_cyc_r, s2_cyc_r, s3_cyc_r, s4_cyc_r;
  logic [10:0] s2_rem_r, s3_rem_r, s4_rem_r;
  logic [1:0]  s3_yr_r, s4_yr_r;
  logic [3:0]  s4_mo_r;
  logic [10:0] s4_start_r;
  logic [5:0]  out_sec_r, out_min_r;
  logic [4:0]  out_hr_r, out_day_r;
  logic [3:0]  out_mo_r;
  logic [7:0]  out_yoff_r;

  logic [32:0] cyc_prod;
  logic [10:0] rem_nxt;
  logic [1:0]  yr_nxt;
  logic [5:0]  base;
  logic [3:0]  mo_nxt;
  logic [10:0] start_nxt;

  assign cyc_prod = 33'(in_tod.days) * 33'(s2dt_pkg::DIV1461_M16);
  // remainder is below 1461, so eleven bits suffice
  assign rem_nxt  = s1_tod_r.days[10:0] - ({5'd0, s1_cyc_r} * s2dt_pkg::DAYS_PER_CYCLE);

  always_comb begin
    if (s2_rem_r >= s2dt_pkg::CYCLE_MONTH_START[36])      yr_nxt = 2'd3;
    else if (s2_rem_r >= s2dt_pkg::CYCLE_MONTH_START[24]) yr_nxt = 2'd2;
    else if (s2_rem_r >= s2dt_pkg::CYCLE_MONTH_START[12]) yr_nxt = 2'd1;
    else                                                 yr_nxt = 2'd0;
  end

  assign base = 6'({s3_yr_r, 3'b000}) + 6'({s3_yr_r, 2'b00});

  // month starts ascend, so the last start not past rem wins
  always_comb begin
    mo_nxt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (s3_rem_r >= s2dt_pkg::CYCLE_MONTH_START[base + 6'(k)]) mo_nxt = 4'(k);
    end
    start_nxt = s2dt_pkg::CYCLE_MONTH_START[base + {2'b00, mo_nxt}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tod_r   <= in_tod;
    s1_cyc_r   <= cyc_prod[32:27];
    s2_tod_r   <= s1_tod_r;
    s2_cyc_r   <= s1_cyc_r;
    s2_rem_r   <= rem_nxt;
    s3_tod_r   <= s2_tod_r;
    s3_cyc_r   <= s2_cyc_r;
    s3_rem_r   <= s2_rem_r;
    s3_yr_r    <= yr_nxt;
    s4_tod_r   <= s3_tod_r;
    s4_cyc_r   <= s3_cyc_r;
    s4_rem_r   <= s3_rem_r;
    s4_yr_r    <= s3_yr_r;
    s4_mo_r    <= mo_nxt;
    s4_start_r <= start_nxt;
    out_sec_r  <= s4_tod_r.second;
    out_min_r  <= s4_tod_r.minute;
    out_hr_r   <= s4_tod_r.hour;
    out_day_r  <= 5'(s4_rem_r - s4_start_r) + 5'd1;
    out_mo_r   <= s4_mo_r + 4'd1;
    out_yoff_r <= {s4_cyc_r, s4_yr_r};
  end

  assign out_valid        = v5_r;
  assign out_second       = out_sec_r;
  assign out_minute       = out_min_r;
  assign out_hour         = out_hr_r;
  assign out_day_of_month = out_day_r;
  assign out_month        = out_mo_r;
  assign out_year_offset  = out_yoff_r;

endmodule

### rtl/s2dt_checker.sv
// Port-level checker for the seconds to date/time converter, with its bind.
`include "seconds_to_date_time_top_macros.svh"

module s2dt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [5:0]  out_second,
  input logic [5:0]  out_minute,
  input logic [4:0]  out_hour,
  input logic [4:0]  out_day_of_month,
  input logic [3:0]  out_month,
  input logic [7:0]  out_year_offset
);

  `S2DT_ASSERT_IMPL(a_result_has_request, out_valid, $past(start && !busy, 10),
    "result without request 10 cycles earlier")
  `S2DT_ASSERT_ALWAYS(a_never_busy, !busy, "queue filled although back end never stalls")
  `S2DT_ASSERT_IMPL(a_fields_in_range, out_valid,
    (out_second < 6'd60) && (out_minute < 6'd60) && (out_hour < 5'd24) &&
    (out_day_of_month != 5'd0) && (out_month != 4'd0) && (out_month < 4'd13),
    "result field out of range")
  `S2DT_ASSERT_IMPL(a_leap_day, out_valid && (out_month == 4'd2) && (out_day_of_month > 5'd28),
    (out_day_of_month == 5'd29) && (out_year_offset[1:0] == 2'd0),
    "February day past 28 outside leap year")
  `S2DT_ASSERT_IMPL(a_short_months,
    out_valid && ((out_month == 4'd4) || (out_month == 4'd6) ||
    (out_month == 4'd9) || (out_month == 4'd11)),
    out_day_of_month < 5'd31, "day 31 in a 30-day month")

endmodule

bind seconds_to_date_time_top s2dt_checker u_s2dt_checker (.*);

### dv/tb_seconds_to_date_time_top.sv
// Self-checking testbench for the seconds to date/time converter top level.
`timescale 1ns / 100ps

module tb_seconds_to_date_time_top;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] year_offset;
  } cal_t;

  typedef struct packed {
    logic [31:0] secs;
    cal_t        cal;
  } due_entry_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        typed;
    cal_t        want;
  } dir_row_t;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned CYCLE_DAYS   = 1461;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int N_DIRECTED = 24;
  localparam int N_PER_PHASE = 550;

  // typed expectations only for time zero and the field extremes
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{32'd0,          1'b1, '{6'd0,  6'd0,  5'd0,  5'd1, 4'd1, 8'd0}},
    '{32'd59,         1'b1, '{6'd59, 6'd0,  5'd0,  5'd1, 4'd1, 8'd0}},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 5'd1, 4'd1, 8'd0}},
    '{32'd86400,      1'b0, '0},
    '{32'd2678399,    1'b0, '0},
    '{32'd2678400,    1'b0, '0},
    '{32'd5097600,    1'b0, '0},
    '{32'd5184000,    1'b0, '0},
    '{32'd31622399,   1'b0, '0},
    '{32'd31622400,   1'b0, '0},
    '{32'd36720000,   1'b0, '0},
    '{32'd126230399,  1'b0, '0},
    '{32'd126230400,  1'b0, '0},
    '{32'd3160771200, 1'b0, '0},
    '{32'd3160857600, 1'b0, '0},
    '{32'd4291833600, 1'b0, '0},
    '{32'hAAAAAAAA,   1'b0, '0},
    '{32'h55555555,   1'b0, '0},
    '{32'h7FFFFFFF,   1'b0, '0},
    '{32'h80000000,   1'b0, '0},
    '{32'hFFFFFFFF,   1'b1, '{6'd15, 6'd28, 5'd6,  5'd6, 4'd2, 8'd136}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month;
  logic [7:0]  out_year_offset;

  due_entry_t  calendar_due [$];
  int unsigned idle_pct;
  int unsigned mismatch_count;

  seconds_to_date_time_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year_offset  (out_year_offset)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Walks whole years, then whole months; first year of each cycle is leap.
  function automatic cal_t to_calendar(input logic [31:0] secs);
    cal_t        r;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mo;
    int unsigned ylen;
    int unsigned mlen;
    t = secs;
    r.second = 6'(t % 60);
    t = t / 60;
    r.minute = 6'(t % 60);
    t = t / 60;
    r.hour = 5'(t % 24);
    days = t / 24;
    r.year_offset = 8'((days / CYCLE_DAYS) * 4);
    days = days % CYCLE_DAYS;
    yr = 0;
    ylen = 366;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = 365;
    end
    mo = 1;
    mlen = 31;
    while (days >= mlen) begin
      days -= mlen;
      mo++;
      mlen = MONTH_DAYS[mo - 1] + ((mo == 2 && yr == 0) ? 1 : 0);
    end
    r.day_of_month = 5'(days + 1);
    r.month = 4'(mo);
    r.year_offset = r.year_offset + 8'(yr);
    return r;
  endfunction

  function automatic logic [31:0] pick_secs();
    logic [31:0] s;
    case ($urandom_range(4))
      0, 1: s = $urandom;
      // just at a midnight or one second before the next one
      2: s = $urandom_range(49709) * SECS_PER_DAY + ($urandom_range(1) ? 0 : SECS_PER_DAY - 1);
      3: s = 32'hFFFFFFFF - $urandom_range(100000000);
      default: s = $urandom_range(3 * CYCLE_DAYS * SECS_PER_DAY);
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] secs,
                                 input int unsigned got, input int unsigned want);
    $display("[%0t] MISMATCH %s for secs=%0d: got %0d, want %0d", $realtime, what, secs,
             got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [31:0] secs, input logic typed, input cal_t want);
    due_entry_t e;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    e.secs = secs;
    e.cal  = typed ? want : to_calendar(secs);
    calendar_due.push_back(e);
  endtask

  always @(posedge clk) begin
    due_entry_t e;
    if (rst_n && out_valid) begin
      if (calendar_due.size() == 0) begin
        report_mismatch("result with no request pending", 32'd0, 0, 0);
      end else begin
        e = calendar_due.pop_front();
        if (out_second !== e.cal.second)
          report_mismatch("second", e.secs, 32'(out_second), 32'(e.cal.second));
        if (out_minute !== e.cal.minute)
          report_mismatch("minute", e.secs, 32'(out_minute), 32'(e.cal.minute));
        if (out_hour !== e.cal.hour)
          report_mismatch("hour", e.secs, 32'(out_hour), 32'(e.cal.hour));
        if (out_day_of_month !== e.cal.day_of_month)
          report_mismatch("day_of_month", e.secs, 32'(out_day_of_month),
                          32'(e.cal.day_of_month));
        if (out_month !== e.cal.month)
          report_mismatch("month", e.secs, 32'(out_month), 32'(e.cal.month));
        if (out_year_offset !== e.cal.year_offset)
          report_mismatch("year_offset", e.secs, 32'(out_year_offset),
                          32'(e.cal.year_offset));
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_epoch_seconds = '0;
    idle_pct         = 0;
    mismatch_count   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(DIRECTED[i].secs, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 19 : (phase == 1) ? 45 : 0;
      repeat (N_PER_PHASE) send_request(pick_secs(), 1'b0, '0);
    end
    start <= 1'b0;

    while (calendar_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
